### rtl/core/itaf_pkg.sv
// itaf_pkg: shared types, constants and helpers for the integer to ASCII formatter.
// Holds the sequencer state type, ASCII codes and the digit character function.
// No dependencies.
package itaf_pkg;

  localparam int VALUE_BITS      = 64;
  localparam int MAX_FIELD_WIDTH = 63;
  localparam int FW_W            = 6;

  localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
  localparam int HEX_BITS   = 4 * HEX_DIGITS;
  localparam int BCNT_W     = $clog2(VALUE_BITS);
  localparam int ND_W       = $clog2(DEC_DIGITS + 1);
  localparam int IDX_W      = $clog2(DEC_DIGITS);

  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_LOWER_A = 8'h61;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONVERT,
    S_COUNT,
    S_LAYOUT,
    S_EMIT
  } state_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] ch;
    if (nib < 4'd10) begin
      ch = CH_ZERO + {4'd0, nib};
    end else if (upper) begin
      ch = CH_UPPER_A + {4'd0, nib - 4'd10};
    end else begin
      ch = CH_LOWER_A + {4'd0, nib - 4'd10};
    end
    return ch;
  endfunction

endpackage

### rtl/core/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: printf style integer to ASCII character stream.
// Shift-add-3 binary to BCD sequencer, digit count, layout and character emitter.
// Depends on itaf_pkg.

// A request is taken when start is high and busy is low; busy then stays high
// until the last character has been issued. Characters come out one per cycle
// on out_char, each marked by valid for exactly one cycle, with last_char set
// on the final one; the receiver cannot stall, so it must take every character
// as it appears. A decimal request first passes through the shift-add-3 unit,
// which shifts in one value bit per cycle and turns the magnitude into BCD
// digits; a hex request skips that unit. The digits are then counted and the
// field laid out, and max(field_width, sign + digits) characters are issued.
module integer_to_ascii_formatter (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [63:0]              value,
  input  logic                     signed_mode,
  input  logic                     hex_base,
  input  logic                     upper_digits,
  input  logic                     plus_sign,
  input  logic [itaf_pkg::FW_W-1:0] field_width,
  input  logic                     zero_pad,
  output logic                     valid,
  output logic [7:0]               out_char,
  output logic                     last_char
);
  import itaf_pkg::*;

  state_t state, state_next;

  logic [VALUE_BITS-1:0] mag;
  logic [BCNT_W-1:0]     bitcnt;
  logic [3:0]            dig [DEC_DIGITS];
  logic [3:0]            dig_next [DEC_DIGITS];
  logic [3:0]            adj [DEC_DIGITS];
  logic [ND_W-1:0]       nd;
  logic [ND_W-1:0]       nd_calc;
  logic [FW_W-1:0]       wsat;
  logic [FW_W-1:0]       rem;
  logic                  first;
  logic                  neg;
  logic                  has_sign;
  logic                  upper;
  logic                  zpad;
  logic                  hex;

  logic                  accept;
  logic                  do_shift;
  logic                  do_count;
  logic                  do_layout;
  logic                  do_emit;

  logic [VALUE_BITS-1:0] v_in;
  logic                  neg_in;
  logic [VALUE_BITS-1:0] mag_in;
  logic [HEX_BITS-1:0]   mag_hex;
  logic [FW_W-1:0]       body;
  logic [FW_W-1:0]       total;
  logic [7:0]            char_sel;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign v_in    = value[VALUE_BITS-1:0];
  assign neg_in  = signed_mode && v_in[VALUE_BITS-1];
  assign mag_in  = neg_in ? (~v_in + 1'b1) : v_in;
  assign mag_hex = HEX_BITS'(mag_in);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = hex_base ? S_COUNT : S_CONVERT;
        end
      end
      S_CONVERT: begin
        if (bitcnt == '0) begin
          state_next = S_COUNT;
        end
      end
      S_COUNT:  state_next = S_LAYOUT;
      S_LAYOUT: state_next = S_EMIT;
      S_EMIT: begin
        if (rem == '0) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    do_shift  = 1'b0;
    do_count  = 1'b0;
    do_layout = 1'b0;
    do_emit   = 1'b0;
    unique case (state)
      S_IDLE:    ;
      S_CONVERT: do_shift  = 1'b1;
      S_COUNT:   do_count  = 1'b1;
      S_LAYOUT:  do_layout = 1'b1;
      S_EMIT:    do_emit   = 1'b1;
      default:   ;
    endcase
  end

  // shift-add-3 step over all BCD digits
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[i] = (dig[i] >= 4'd5) ? (dig[i] + 4'd3) : dig[i];
    end
    for (int i = 0; i < DEC_DIGITS; i++) begin
      if (i == 0) begin
        dig_next[i] = {adj[i][2:0], mag[VALUE_BITS-1]};
      end else begin
        dig_next[i] = {adj[i][2:0], adj[i-1][3]};
      end
    end
  end

  always_comb begin
    nd_calc = ND_W'(1);
    for (int i = 1; i < DEC_DIGITS; i++) begin
      if (dig[i] != 4'd0) begin
        nd_calc = ND_W'(i + 1);
      end
    end
  end

  assign body  = FW_W'(nd) + FW_W'(has_sign);
  assign total = (wsat > body) ? wsat : body;

  always_comb begin
    if (rem < FW_W'(nd)) begin
      char_sel = digit_char(dig[rem[IDX_W-1:0]], upper);
    end else if (zpad) begin
      char_sel = (first && has_sign) ? (neg ? CH_MINUS : CH_PLUS) : CH_ZERO;
    end else begin
      char_sel = ((rem == FW_W'(nd)) && has_sign) ? (neg ? CH_MINUS : CH_PLUS) : CH_SPACE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      valid <= do_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      mag      <= mag_in;
      bitcnt   <= BCNT_W'(VALUE_BITS - 1);
      neg      <= neg_in;
      has_sign <= neg_in || plus_sign;
      upper    <= hex_base && upper_digits;
      zpad     <= zero_pad;
      hex      <= hex_base;
      wsat     <= (field_width > FW_W'(MAX_FIELD_WIDTH)) ? FW_W'(MAX_FIELD_WIDTH) : field_width;
      for (int i = 0; i < DEC_DIGITS; i++) begin
        if (hex_base && (i < HEX_DIGITS)) begin
          dig[i] <= mag_hex[4*i +: 4];
        end else begin
          dig[i] <= 4'd0;
        end
      end
    end else if (do_shift) begin
      mag    <= {mag[VALUE_BITS-2:0], 1'b0};
      bitcnt <= bitcnt - 1'b1;
      for (int i = 0; i < DEC_DIGITS; i++) begin
        dig[i] <= dig_next[i];
      end
    end
    if (do_count) begin
      nd <= nd_calc;
    end
    if (do_layout) begin
      rem   <= total - 1'b1;
      first <= 1'b1;
    end else if (do_emit) begin
      rem   <= rem - 1'b1;
      first <= 1'b0;
    end
    if (do_emit) begin
      out_char  <= char_sel;
      last_char <= (rem == '0);
    end
  end

  a_last_ends_burst: assert property (@(posedge clk) disable iff (rst)
    valid && last_char |=> !valid)
    else $error("character issued right after the last one");

  a_accept_sets_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("request accepted but sequencer stayed idle");

  a_midstream_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last_char |-> busy)
    else $error("sequencer went idle before the last character");

  a_digit_count: assert property (@(posedge clk) disable iff (rst)
    state == S_EMIT |-> (nd != '0) && (nd <= ND_W'(DEC_DIGITS)))
    else $error("digit count out of range while emitting");

  a_hex_skips_convert: assert property (@(posedge clk) disable iff (rst)
    state == S_CONVERT |-> !hex)
    else $error("hex request entered the BCD conversion");

endmodule

### bench/tb.sv
// tb: self-checking bench for integer_to_ascii_formatter, printf style integer formatting.
// Random and directed requests go in; each character is checked against its own predicted string.
// Depends on itaf_pkg and the integer_to_ascii_formatter RTL.
module tb;
  import itaf_pkg::*;

  localparam int IDLE_LIMIT  = 3000;
  localparam int END_SETTLE  = 100;
  localparam int RANDOM_REQS = 140;

  typedef struct {
    logic [63:0] value;
    logic        signed_mode;
    logic        hex_base;
    logic        upper_digits;
    logic        plus_sign;
    logic [5:0]  field_width;
    logic        zero_pad;
    bit          drain_first;
  } fmt_req_t;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } fmt_char_t;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [63:0] value;
  logic        signed_mode;
  logic        hex_base;
  logic        upper_digits;
  logic        plus_sign;
  logic [5:0]  field_width;
  logic        zero_pad;
  logic        valid;
  logic [7:0]  out_char;
  logic        last_char;

  fmt_req_t  pending_requests[$];
  fmt_char_t expected_chars[$];
  bit        took;
  int        idle_cycles;
  int        mismatches;
  int        burst_left;
  int        gap_left;

  integer_to_ascii_formatter dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .signed_mode (signed_mode),
    .hex_base    (hex_base),
    .upper_digits(upper_digits),
    .plus_sign   (plus_sign),
    .field_width (field_width),
    .zero_pad    (zero_pad),
    .valid       (valid),
    .out_char    (out_char),
    .last_char   (last_char)
  );

  function automatic fmt_req_t make_req(input logic [63:0] v, input logic sm, input logic hx,
                                        input logic up, input logic pl, input logic [5:0] fw,
                                        input logic zp, input bit drain);
    fmt_req_t r;
    r.value        = v;
    r.signed_mode  = sm;
    r.hex_base     = hx;
    r.upper_digits = up;
    r.plus_sign    = pl;
    r.field_width  = fw;
    r.zero_pad     = zp;
    r.drain_first  = drain;
    return r;
  endfunction

  // Build the formatted string of one request and queue its characters.
  function automatic void queue_formatted_chars(input fmt_req_t r);
    logic        neg;
    logic        has_sign;
    logic [63:0] mag;
    logic [3:0]  d;
    logic [7:0]  sign_ch;
    logic [7:0]  digits[$];
    logic [7:0]  text[$];
    int          body;
    int          npad;
    fmt_char_t   c;
    neg = r.signed_mode && r.value[63];
    mag = neg ? (~r.value + 64'd1) : r.value;
    do begin
      if (r.hex_base) begin
        d   = mag[3:0];
        mag = mag >> 4;
      end else begin
        d   = 4'(mag % 64'd10);
        mag = mag / 64'd10;
      end
      if (d < 4'd10) begin
        digits.push_front(CH_ZERO + {4'd0, d});
      end else begin
        digits.push_front((r.upper_digits ? CH_UPPER_A : CH_LOWER_A) + {4'd0, d - 4'd10});
      end
    end while (mag != 64'd0);
    has_sign = neg || r.plus_sign;
    sign_ch  = neg ? CH_MINUS : CH_PLUS;
    body     = digits.size() + (has_sign ? 1 : 0);
    npad     = (int'(r.field_width) > body) ? int'(r.field_width) - body : 0;
    if (r.zero_pad) begin
      if (has_sign) text.push_back(sign_ch);
      repeat (npad) text.push_back(CH_ZERO);
    end else begin
      repeat (npad) text.push_back(CH_SPACE);
      if (has_sign) text.push_back(sign_ch);
    end
    foreach (digits[i]) text.push_back(digits[i]);
    foreach (text[i]) begin
      c.ch   = text[i];
      c.last = (i == text.size() - 1);
      expected_chars.push_back(c);
    end
  endfunction

  function automatic logic [63:0] random_value();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: v = v >> $urandom_range(0, 63);
      1: v = 64'($urandom_range(0, 20));
      2: v = ~(64'($urandom_range(0, 20)));
      3: v = v ^ (64'd1 << 63);
      default: ;
    endcase
    return v;
  endfunction

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Drive requests in bursts with random gaps; hold start until the request is taken.
  always @(negedge clk) begin : drive_requests
    fmt_req_t r;
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start    <= 1'b0;
      end else if (pending_requests.size() == 0 ||
                   (pending_requests[0].drain_first && (expected_chars.size() != 0 || busy))) begin
        start <= 1'b0;
      end else begin
        r = pending_requests.pop_front();
        value        <= r.value;
        signed_mode  <= r.signed_mode;
        hex_base     <= r.hex_base;
        upper_digits <= r.upper_digits;
        plus_sign    <= r.plus_sign;
        field_width  <= r.field_width;
        zero_pad     <= r.zero_pad;
        start        <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 10);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
        end else begin
          burst_left <= burst_left - 1;
        end
      end
    end
  end

  // Predict on each taken request; check each character strobe.
  always @(posedge clk) begin : watch_outputs
    fmt_char_t e;
    if (rst) begin
      took = 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        queue_formatted_chars(make_req(value, signed_mode, hex_base, upper_digits, plus_sign,
                                       field_width, zero_pad, 1'b0));
      end
      if (valid) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character %h", out_char);
          mismatches++;
        end else begin
          e = expected_chars.pop_front();
          if (out_char !== e.ch) begin
            $error("out_char: expected %h, got %h", e.ch, out_char);
            mismatches++;
          end
          if (last_char !== e.last) begin
            $error("last_char: expected %b, got %b", e.last, last_char);
            mismatches++;
          end
        end
      end
    end
    idle_cycles = (took || valid) ? 0 : idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("tb: FAIL");
    $finish;
  end

  initial begin
    fmt_req_t r;
    rst          = 1'b1;
    start        = 1'b0;
    value        = '0;
    signed_mode  = 1'b0;
    hex_base     = 1'b0;
    upper_digits = 1'b0;
    plus_sign    = 1'b0;
    field_width  = '0;
    zero_pad     = 1'b0;
    took         = 1'b0;
    idle_cycles  = 0;
    mismatches   = 0;
    burst_left   = 4;
    gap_left     = 0;

    pending_requests.push_back(make_req(64'd0, 0, 0, 0, 0, 6'd0, 0, 0));
    pending_requests.push_back(make_req(64'd0, 0, 1, 0, 0, 6'd0, 0, 0));
    pending_requests.push_back(make_req(64'd0, 1, 0, 0, 1, 6'd5, 1, 0));
    pending_requests.push_back(make_req(64'd0, 0, 0, 0, 1, 6'd5, 0, 0));
    pending_requests.push_back(make_req('1, 0, 0, 0, 0, 6'd0, 0, 0));
    pending_requests.push_back(make_req('1, 0, 1, 1, 0, 6'd0, 0, 0));
    pending_requests.push_back(make_req('1, 0, 1, 0, 0, 6'd0, 0, 0));
    pending_requests.push_back(make_req(64'h8000_0000_0000_0000, 1, 0, 0, 0, 6'd0, 0, 0));
    pending_requests.push_back(make_req(64'h8000_0000_0000_0000, 1, 1, 1, 1, 6'd25, 1, 1));
    pending_requests.push_back(make_req('1, 1, 0, 0, 1, 6'd0, 0, 0));
    pending_requests.push_back(make_req(64'd12345, 0, 0, 0, 1, 6'd8, 1, 0));
    pending_requests.push_back(make_req(64'd12345, 0, 0, 1, 0, 6'd63, 0, 0));
    pending_requests.push_back(make_req(-64'sd987654321, 1, 0, 0, 0, 6'd63, 1, 0));
    pending_requests.push_back(make_req(-64'sd42, 1, 1, 0, 0, 6'd63, 0, 0));
    pending_requests.push_back(make_req(64'hABCD_EF01_2345_6789, 0, 1, 0, 0, 6'd1, 0, 0));
    pending_requests.push_back(make_req(64'hABCD_EF01_2345_6789, 0, 1, 1, 1, 6'd17, 1, 0));
    pending_requests.push_back(make_req(64'h7FFF_FFFF_FFFF_FFFF, 1, 0, 0, 1, 6'd20, 0, 0));
    pending_requests.push_back(make_req(64'd9, 0, 0, 0, 0, 6'd1, 1, 0));
    pending_requests.push_back(make_req(64'hF, 1, 1, 1, 0, 6'd2, 1, 0));
    pending_requests.push_back(make_req(-64'sd1, 1, 1, 0, 1, 6'd3, 0, 0));

    repeat (RANDOM_REQS) begin
      r = make_req(random_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                               : 6'($urandom_range(0, 24)),
                   1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0);
      pending_requests.push_back(r);
    end

    repeat (9) @(negedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || start || expected_chars.size() != 0 || busy)
      @(negedge clk);
    repeat (END_SETTLE) @(negedge clk);

    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
